>>> rtl/core/vblc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the vehicle blocks link check unit.
// Depends on nothing; imported by the top level.
package vblc_pkg;

  localparam int COORD_W = 24;
  localparam int TRIG_W  = 16;
  localparam int DIM_W   = 12;

  localparam logic [DIM_W-1:0] LENGTH_RESET = 12'd1178;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd461;

  typedef enum logic [1:0] {
    REASON_STRADDLE = 2'd0,
    REASON_SHARED   = 2'd1,
    REASON_OUTSIDE  = 2'd2,
    REASON_ONE_SIDE = 2'd3
  } reason_t;

  typedef enum logic {
    REG_LENGTH = 1'b0,
    REG_WIDTH  = 1'b1
  } cfg_index_t;

endpackage

>>> rtl/core/vehicle_blocks_link_check_unit.sv
`timescale 1ns / 1ps
// Pipelined test of whether a rotated vehicle rectangle blocks a sender-receiver line.
// Depends on vblc_pkg for widths, register indexes and decision codes.
//
// Usage:
//   Input channel: in_valid with the three positions and the heading; a transaction
//   completes at a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid with blocked and decision_reason; a transaction
//   completes at a rising edge with out_valid high and out_stall low.
//   Configuration channel: cfg_valid, cfg_index, cfg_data; cfg_ready is always high.
//   Index 0 sets the vehicle length, index 1 the vehicle width.
//   Throughput is one transaction per cycle unless stalled; the six register stages are:
//   input capture, differences and extent products, line products, product
//   differences, partial corner sums, and the corner sign decision.
//   Each stage holds its item only when the stage after it is full and held, so
//   an output stall fills the empty stages before in_stall rises.
//   Reset empties every stage and restores length 4.6 m and width 1.8 m.
//   The register values are sampled when an item is accepted.
module vehicle_blocks_link_check_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vblc_pkg::COORD_W-1:0] sender_x,
  input  logic signed [vblc_pkg::COORD_W-1:0] sender_y,
  input  logic signed [vblc_pkg::COORD_W-1:0] receiver_x,
  input  logic signed [vblc_pkg::COORD_W-1:0] receiver_y,
  input  logic signed [vblc_pkg::COORD_W-1:0] obstacle_x,
  input  logic signed [vblc_pkg::COORD_W-1:0] obstacle_y,
  input  logic signed [vblc_pkg::TRIG_W-1:0]  heading_cos,
  input  logic signed [vblc_pkg::TRIG_W-1:0]  heading_sin,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                blocked,
  output vblc_pkg::reason_t                   decision_reason,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  vblc_pkg::cfg_index_t                cfg_index,
  input  logic [vblc_pkg::DIM_W-1:0]          cfg_data
);
  import vblc_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int BOX_W  = COORD_W + 3;
  localparam int EXT_W  = TRIG_W + DIM_W + 1;
  localparam int BP_W   = 2 * DIFF_W;
  localparam int EP_W   = DIFF_W + EXT_W;
  localparam int BASE_W = BP_W + 1;
  localparam int PQ_W   = EP_W + 1;
  localparam int SUM_W  = BASE_W + 17;

  logic [DIM_W-1:0] vehicle_length;
  logic [DIM_W-1:0] vehicle_width;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  logic signed [COORD_W-1:0] s1_sx, s1_sy, s1_rx, s1_ry, s1_ox, s1_oy;
  logic signed [TRIG_W-1:0]  s1_hc, s1_hs;
  logic [DIM_W-1:0]          s1_len, s1_wid;

  logic signed [DIFF_W-1:0] s2_a, s2_c, s2_dx, s2_dy;
  logic signed [EXT_W-1:0]  s2_cl, s2_sl, s2_cw, s2_sw;
  logic                     s2_early;
  reason_t                  s2_reason;

  logic signed [BP_W-1:0] s3_adx, s3_cdy;
  logic signed [EP_W-1:0] s3_acl, s3_csl, s3_asw, s3_ccw;
  logic                   s3_early;
  reason_t                s3_reason;

  logic signed [BASE_W-1:0] s4_base;
  logic signed [PQ_W-1:0]   s4_p, s4_q;
  logic                     s4_early;
  reason_t                  s4_reason;

  logic signed [SUM_W-1:0] s5_hp, s5_hm;
  logic signed [PQ_W-1:0]  s5_q;
  logic                    s5_early;
  reason_t                 s5_reason;

  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [BOX_W-1:0]   lo_x, hi_x, lo_y, hi_y, ox2, oy2, len_box;
  logic                      shared_pos, outside_box;
  logic signed [SUM_W-1:0]   base_sh;
  logic signed [SUM_W-1:0]   corner0, corner1, corner2, corner3, q_ext;
  logic [3:0]                pos_side, neg_side;
  logic                      one_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_length <= LENGTH_RESET;
      vehicle_width  <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LENGTH: vehicle_length <= cfg_data;
        REG_WIDTH:  vehicle_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en6 = !out_valid || !out_stall;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sx  <= sender_x;
      s1_sy  <= sender_y;
      s1_rx  <= receiver_x;
      s1_ry  <= receiver_y;
      s1_ox  <= obstacle_x;
      s1_oy  <= obstacle_y;
      s1_hc  <= heading_cos;
      s1_hs  <= heading_sin;
      s1_len <= vehicle_length;
      s1_wid <= vehicle_width;
    end
  end

  always_comb begin
    shared_pos = ((s1_sx == s1_ox) && (s1_sy == s1_oy)) ||
                 ((s1_rx == s1_ox) && (s1_ry == s1_oy));
    min_x   = (s1_sx < s1_rx) ? s1_sx : s1_rx;
    max_x   = (s1_sx > s1_rx) ? s1_sx : s1_rx;
    min_y   = (s1_sy < s1_ry) ? s1_sy : s1_ry;
    max_y   = (s1_sy > s1_ry) ? s1_sy : s1_ry;
    len_box = $signed(BOX_W'({1'b0, s1_len}));
    lo_x    = BOX_W'($signed({min_x, 1'b0})) - len_box;
    hi_x    = BOX_W'($signed({max_x, 1'b0})) + len_box;
    lo_y    = BOX_W'($signed({min_y, 1'b0})) - len_box;
    hi_y    = BOX_W'($signed({max_y, 1'b0})) + len_box;
    ox2     = BOX_W'($signed({s1_ox, 1'b0}));
    oy2     = BOX_W'($signed({s1_oy, 1'b0}));
    outside_box = (ox2 < lo_x) || (ox2 > hi_x) || (oy2 < lo_y) || (oy2 > hi_y);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_a  <= DIFF_W'(s1_ry) - DIFF_W'(s1_sy);
      s2_c  <= DIFF_W'(s1_rx) - DIFF_W'(s1_sx);
      s2_dx <= DIFF_W'(s1_ox) - DIFF_W'(s1_rx);
      s2_dy <= DIFF_W'(s1_oy) - DIFF_W'(s1_ry);
      s2_cl <= EXT_W'(s1_hc) * EXT_W'($signed({1'b0, s1_len}));
      s2_sl <= EXT_W'(s1_hs) * EXT_W'($signed({1'b0, s1_len}));
      s2_cw <= EXT_W'(s1_hc) * EXT_W'($signed({1'b0, s1_wid}));
      s2_sw <= EXT_W'(s1_hs) * EXT_W'($signed({1'b0, s1_wid}));
      s2_early  <= shared_pos || outside_box;
      s2_reason <= shared_pos ? REASON_SHARED : REASON_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_adx    <= BP_W'(s2_a) * BP_W'(s2_dx);
      s3_cdy    <= BP_W'(s2_c) * BP_W'(s2_dy);
      s3_acl    <= EP_W'(s2_a) * EP_W'(s2_cl);
      s3_csl    <= EP_W'(s2_c) * EP_W'(s2_sl);
      s3_asw    <= EP_W'(s2_a) * EP_W'(s2_sw);
      s3_ccw    <= EP_W'(s2_c) * EP_W'(s2_cw);
      s3_early  <= s2_early;
      s3_reason <= s2_reason;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_base   <= BASE_W'(s3_adx) - BASE_W'(s3_cdy);
      s4_p      <= PQ_W'(s3_acl) - PQ_W'(s3_csl);
      s4_q      <= PQ_W'(s3_asw) + PQ_W'(s3_ccw);
      s4_early  <= s3_early;
      s4_reason <= s3_reason;
    end
  end

  assign base_sh = SUM_W'(s4_base) <<< 15;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_hp     <= base_sh + SUM_W'(s4_p);
      s5_hm     <= base_sh - SUM_W'(s4_p);
      s5_q      <= s4_q;
      s5_early  <= s4_early;
      s5_reason <= s4_reason;
    end
  end

  always_comb begin
    q_ext    = SUM_W'(s5_q);
    corner0  = s5_hp - q_ext;
    corner1  = s5_hm - q_ext;
    corner2  = s5_hm + q_ext;
    corner3  = s5_hp + q_ext;
    neg_side = {corner3[SUM_W-1], corner2[SUM_W-1], corner1[SUM_W-1], corner0[SUM_W-1]};
    pos_side = {!corner3[SUM_W-1] && (corner3 != '0), !corner2[SUM_W-1] && (corner2 != '0),
                !corner1[SUM_W-1] && (corner1 != '0), !corner0[SUM_W-1] && (corner0 != '0)};
    one_side = (&pos_side) || (&neg_side);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      if (s5_early) begin
        blocked         <= 1'b0;
        decision_reason <= s5_reason;
      end else if (one_side) begin
        blocked         <= 1'b0;
        decision_reason <= REASON_ONE_SIDE;
      end else begin
        blocked         <= 1'b1;
        decision_reason <= REASON_STRADDLE;
      end
    end
  end

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("Accepted transaction did not reach the capture stage.");

  a_last_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (v5 && !(out_valid && out_stall)) |=> out_valid)
    else $error("Final stage item was not moved to the output register.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !v1 && !v5))
    else $error("Pipeline not empty after reset.");

endmodule
